>>> rtl/core/lsc_pkg.sv
// Shared types and constants for the fully associative LRU sector cache.
`default_nettype none

package lsc_pkg;

  // Cache geometry
  localparam int unsigned MaxEntries = 16;
  localparam int unsigned KeyW       = 24;
  localparam int unsigned HandleW    = 16;
  localparam int unsigned IdxW       = $clog2(MaxEntries);
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);

  // Fixed field widths of the ports
  localparam int unsigned CapW  = 5;
  localparam int unsigned OccW  = 5;
  localparam logic [CapW-1:0] CapReset = CapW'(16);

  // Operation codes
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_FLUSH  = 2'd3
  } lsc_op_e;

  typedef struct packed {
    lsc_op_e            mode;
    logic [KeyW-1:0]    frame_address;
    logic [HandleW-1:0] entry_ref;
  } lsc_req_t;

  typedef struct packed {
    logic               hit;
    logic [HandleW-1:0] found_ref;
    logic               evicted;
    logic [KeyW-1:0]    evicted_address;
    logic [OccW-1:0]    occupancy;
  } lsc_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/lru_sector_cache.sv
// Fully associative LRU sector cache: request register, tag match and rank update, result register.
//
// Usage:
//   Requests enter on in_valid_i/in_ready_o carrying in_req_i (mode, frame address,
//   entry handle). Modes: lookup, insert, remove, flush. Each request gives exactly
//   one result on out_valid_o/out_ready_i carrying out_rsp_o (hit, found handle,
//   eviction flag and key, occupancy after the request).
//   An accepted request sits in the request register; then all 16 tag compares, the
//   recency rank update and the result are formed in one pass into the result
//   register. Throughput is one request per cycle while the receiver takes results,
//   set by that single-pass match and rank update.
//   When the receiver stalls, the result register holds; one more request is
//   taken into the request register, after which in_ready_o drops until the
//   result is taken.
//   Reset empties the cache (all entries invalid, occupancy 0; no clearing pass is needed)
//   and sets capacity to 16. Capacity is written through cfg_we_i/cfg_wdata_i only while
//   idle; the user must keep this, the block does not enforce it. Zero acts as 1, values above 16 as 16.
`default_nettype none

module lru_sector_cache (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output      logic                    in_ready_o,
  input  wire lsc_pkg::lsc_req_t       in_req_i,
  output      logic                    out_valid_o,
  input  wire logic                    out_ready_i,
  output      lsc_pkg::lsc_rsp_t       out_rsp_o,
  input  wire logic                    cfg_we_i,
  input  wire logic [lsc_pkg::CapW-1:0] cfg_wdata_i
);

  localparam int unsigned N = lsc_pkg::MaxEntries;

  // Control and state registers
  logic                         req_valid_q;
  lsc_pkg::lsc_req_t            req_q;
  logic                         rsp_valid_q;
  lsc_pkg::lsc_rsp_t            rsp_q, rsp_d;
  logic [lsc_pkg::CapW-1:0]     cap_q;
  logic [N-1:0]                 valid_q, valid_d;
  logic [lsc_pkg::IdxW-1:0]     rank_q [N];
  logic [lsc_pkg::IdxW-1:0]     rank_d [N];
  logic [lsc_pkg::CntW-1:0]     count_q, count_d;
  logic [lsc_pkg::KeyW-1:0]     key_q [N];
  logic [lsc_pkg::HandleW-1:0]  handle_q [N];
  logic [N-1:0]                 wr_oh;
  logic                         wr_key;

  logic advance;
  logic step;

  // Advance the work stage when the result register is free or being taken
  assign advance    = !rsp_valid_q || out_ready_i;
  assign step       = req_valid_q && advance;
  assign in_ready_o = !req_valid_q || advance;

  // Tag match, victim search, free slot search and rank update
  always_comb begin
    logic [N-1:0]               match;
    logic                       hit;
    logic [lsc_pkg::IdxW-1:0]   hit_rank;
    logic [lsc_pkg::HandleW-1:0] hit_handle;
    logic [lsc_pkg::CntW-1:0]   eff_cap;
    logic                       do_evict;
    logic [N-1:0]               vic_oh;
    logic                       vic_found;
    logic [lsc_pkg::IdxW-1:0]   vic_rank;
    logic [lsc_pkg::KeyW-1:0]   vic_key;
    logic [N-1:0]               valid1;
    logic [lsc_pkg::IdxW-1:0]   rank1 [N];
    logic [lsc_pkg::CntW-1:0]   count1;
    logic [N-1:0]               free_oh;
    logic                       free_found;

    match      = '0;
    hit_rank   = '0;
    hit_handle = '0;
    for (int i = 0; i < N; i++) begin
      match[i] = valid_q[i] && (key_q[i] == req_q.frame_address);
      if (match[i]) begin
        hit_rank   = hit_rank | rank_q[i];
        hit_handle = hit_handle | handle_q[i];
      end
    end
    hit = |match;

    // Clamp capacity into 1..N
    if (cap_q == '0) begin
      eff_cap = lsc_pkg::CntW'(1);
    end else if (32'(cap_q) > 32'(N)) begin
      eff_cap = lsc_pkg::CntW'(N);
    end else begin
      eff_cap = lsc_pkg::CntW'(cap_q);
    end
    do_evict = (count_q >= eff_cap) && (count_q != '0);

    // Pick the least recent entry
    vic_oh    = '0;
    vic_found = 1'b0;
    vic_rank  = '0;
    vic_key   = '0;
    for (int i = 0; i < N; i++) begin
      if (do_evict && !vic_found && valid_q[i] &&
          (lsc_pkg::CntW'(rank_q[i]) == count_q - lsc_pkg::CntW'(1))) begin
        vic_found = 1'b1;
        vic_oh[i] = 1'b1;
        vic_rank  = rank_q[i];
        vic_key   = key_q[i];
      end
    end

    // State after dropping the victim
    valid1 = valid_q & ~vic_oh;
    count1 = vic_found ? count_q - lsc_pkg::CntW'(1) : count_q;
    for (int i = 0; i < N; i++) begin
      if (vic_oh[i]) begin
        rank1[i] = '0;
      end else if (vic_found && valid1[i] && rank_q[i] > vic_rank) begin
        rank1[i] = rank_q[i] - lsc_pkg::IdxW'(1);
      end else begin
        rank1[i] = rank_q[i];
      end
    end

    // First free slot after the drop
    free_oh    = '0;
    free_found = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (!free_found && !valid1[i]) begin
        free_found = 1'b1;
        free_oh[i] = 1'b1;
      end
    end

    valid_d = valid_q;
    rank_d  = rank_q;
    count_d = count_q;
    wr_oh   = '0;
    wr_key  = 1'b0;
    rsp_d   = '0;

    unique case (req_q.mode)
      lsc_pkg::OP_LOOKUP: begin
        rsp_d.hit = hit;
        if (hit) begin
          rsp_d.found_ref = hit_handle;
          for (int i = 0; i < N; i++) begin
            if (match[i]) begin
              rank_d[i] = '0;
            end else if (valid_q[i] && rank_q[i] < hit_rank) begin
              rank_d[i] = rank_q[i] + lsc_pkg::IdxW'(1);
            end
          end
        end
      end
      lsc_pkg::OP_INSERT: begin
        rsp_d.hit = hit;
        if (hit) begin
          // Replace the handle and promote
          wr_oh = match;
          for (int i = 0; i < N; i++) begin
            if (match[i]) begin
              rank_d[i] = '0;
            end else if (valid_q[i] && rank_q[i] < hit_rank) begin
              rank_d[i] = rank_q[i] + lsc_pkg::IdxW'(1);
            end
          end
        end else begin
          rsp_d.evicted         = vic_found;
          rsp_d.evicted_address = vic_key;
          valid_d = valid1;
          rank_d  = rank1;
          count_d = count1;
          if (free_found) begin
            wr_oh   = free_oh;
            wr_key  = 1'b1;
            valid_d = valid1 | free_oh;
            count_d = count1 + lsc_pkg::CntW'(1);
            for (int i = 0; i < N; i++) begin
              if (free_oh[i]) begin
                rank_d[i] = '0;
              end else if (valid1[i]) begin
                rank_d[i] = rank1[i] + lsc_pkg::IdxW'(1);
              end
            end
          end
        end
      end
      lsc_pkg::OP_REMOVE: begin
        rsp_d.hit = hit;
        if (hit) begin
          valid_d = valid_q & ~match;
          count_d = count_q - lsc_pkg::CntW'(1);
          for (int i = 0; i < N; i++) begin
            if (match[i]) begin
              rank_d[i] = '0;
            end else if (valid_q[i] && rank_q[i] > hit_rank) begin
              rank_d[i] = rank_q[i] - lsc_pkg::IdxW'(1);
            end
          end
        end
      end
      lsc_pkg::OP_FLUSH: begin
        valid_d = '0;
        count_d = '0;
        for (int i = 0; i < N; i++) begin
          rank_d[i] = '0;
        end
      end
      default: begin
        valid_d = valid_q;
      end
    endcase

    rsp_d.occupancy = lsc_pkg::OccW'(count_d);
  end

  // Hold handshake state, cache control state and capacity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
      cap_q       <= lsc_pkg::CapReset;
      valid_q     <= '0;
      count_q     <= '0;
      for (int i = 0; i < N; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (in_ready_o) begin
        req_valid_q <= in_valid_i;
      end
      if (advance) begin
        rsp_valid_q <= req_valid_q;
      end
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (step) begin
        valid_q <= valid_d;
        count_q <= count_d;
        rank_q  <= rank_d;
      end
    end
  end

  // Capture request and result payloads, write key and handle entries
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
    if (step) begin
      rsp_q <= rsp_d;
      for (int i = 0; i < N; i++) begin
        if (wr_oh[i]) begin
          handle_q[i] <= req_q.entry_ref;
          if (wr_key) begin
            key_q[i] <= req_q.frame_address;
          end
        end
      end
    end
  end

  assign out_valid_o = rsp_valid_q;
  assign out_rsp_o   = rsp_q;

`ifndef SYNTHESIS
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(count_q))
    else $error("occupancy count differs from number of valid entries");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(N))
    else $error("occupancy exceeds entry count");

  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && (req_q.mode == lsc_pkg::OP_FLUSH) |=> (count_q == '0) && (valid_q == '0))
    else $error("flush left entries valid");

  a_evict_not_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.evicted |-> !out_rsp_o.hit)
    else $error("eviction reported on a hit");
`endif

endmodule

`default_nettype wire

>>> bench/lsc_cache_check.sv
// Request/result monitor for the LRU sector cache: predicts each result and compares it.
module lsc_cache_check
  import lsc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  lsc_req_t          in_req_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  lsc_rsp_t          out_rsp_i,
  input  logic              cfg_we_i,
  input  logic [CapW-1:0]   cfg_wdata_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the cache contents
  logic [KeyW-1:0]    key_mem [MaxEntries];
  logic [HandleW-1:0] ref_mem [MaxEntries];
  logic               live    [MaxEntries];
  int unsigned        rank    [MaxEntries];
  int unsigned        fill;
  logic [CapW-1:0]    cap_reg;

  lsc_rsp_t expected_rsp_q [$];

  // Move slot s to the front of the recency order.
  function automatic void promote(int s);
    int unsigned r = rank[s];
    for (int i = 0; i < MaxEntries; i++)
      if (live[i] && rank[i] < r) rank[i]++;
    rank[s] = 0;
  endfunction

  // Invalidate slot s and close the gap it leaves in the order.
  function automatic void retire(int s);
    int unsigned r = rank[s];
    live[s] = 1'b0;
    rank[s] = 0;
    for (int i = 0; i < MaxEntries; i++)
      if (live[i] && rank[i] > r) rank[i]--;
    if (fill > 0) fill--;
  endfunction

  // Apply one request to the shadow cache and form its result.
  function automatic lsc_rsp_t predict_cache_op(lsc_req_t req);
    lsc_rsp_t    rsp;
    int          slot;
    int          victim;
    int          free_slot;
    int unsigned eff_cap;
    rsp = '0;
    if (req.mode == OP_FLUSH) begin
      for (int i = 0; i < MaxEntries; i++) begin
        live[i] = 1'b0;
        rank[i] = 0;
      end
      fill = 0;
    end else begin
      slot = -1;
      for (int i = 0; i < MaxEntries; i++)
        if (slot < 0 && live[i] && key_mem[i] == req.frame_address) slot = i;
      rsp.hit = (slot >= 0);
      case (req.mode)
        OP_LOOKUP: begin
          if (slot >= 0) begin
            rsp.found_ref = ref_mem[slot];
            promote(slot);
          end
        end
        OP_REMOVE: begin
          if (slot >= 0) retire(slot);
        end
        default: begin
          if (slot >= 0) begin
            ref_mem[slot] = req.entry_ref;
            promote(slot);
          end else begin
            // zero acts as one, anything above the array size as the array size
            eff_cap = (cap_reg == 0) ? 1 :
                      (cap_reg > MaxEntries) ? MaxEntries : cap_reg;
            if (fill >= eff_cap && fill > 0) begin
              victim = -1;
              for (int i = 0; i < MaxEntries; i++)
                if (victim < 0 && live[i] && rank[i] == fill - 1) victim = i;
              if (victim >= 0) begin
                rsp.evicted         = 1'b1;
                rsp.evicted_address = key_mem[victim];
                retire(victim);
              end
            end
            free_slot = -1;
            for (int i = 0; i < MaxEntries; i++)
              if (free_slot < 0 && !live[i]) free_slot = i;
            if (free_slot >= 0) begin
              for (int i = 0; i < MaxEntries; i++)
                if (live[i]) rank[i]++;
              live[free_slot]    = 1'b1;
              key_mem[free_slot] = req.frame_address;
              ref_mem[free_slot] = req.entry_ref;
              rank[free_slot]    = 0;
              fill++;
            end
          end
        end
      endcase
    end
    rsp.occupancy = OccW'(fill);
    return rsp;
  endfunction

  // Compare results first, then take config and requests seen at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    lsc_rsp_t want;
    if (!rst_ni) begin
      cap_reg = CapReset;
      for (int i = 0; i < MaxEntries; i++) begin
        live[i] = 1'b0;
        rank[i] = 0;
      end
      fill = 0;
      expected_rsp_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: result with no request pending: hit=%0b ref=%h ev=%0b evaddr=%h occ=%0d",
                     $realtime, out_rsp_i.hit, out_rsp_i.found_ref, out_rsp_i.evicted,
                     out_rsp_i.evicted_address, out_rsp_i.occupancy);
        end else begin
          want = expected_rsp_q[0];
          expected_rsp_q.delete(0);
          if (out_rsp_i.hit !== want.hit || out_rsp_i.found_ref !== want.found_ref ||
              out_rsp_i.evicted !== want.evicted ||
              out_rsp_i.evicted_address !== want.evicted_address ||
              out_rsp_i.occupancy !== want.occupancy) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t: result error, exp hit=%0b ref=%h ev=%0b evaddr=%h occ=%0d",
                       $realtime, want.hit, want.found_ref, want.evicted,
                       want.evicted_address, want.occupancy);
              $display("%0t:               got hit=%0b ref=%h ev=%0b evaddr=%h occ=%0d",
                       $realtime, out_rsp_i.hit, out_rsp_i.found_ref, out_rsp_i.evicted,
                       out_rsp_i.evicted_address, out_rsp_i.occupancy);
            end
          end
        end
      end
      if (cfg_we_i) cap_reg = cfg_wdata_i;
      if (in_valid_i && in_ready_i) expected_rsp_q.push_back(predict_cache_op(in_req_i));
    end
    pending_o = expected_rsp_q.size();
  end

endmodule

>>> bench/testbench.sv
// Stimulus and verdict for the LRU sector cache: directed cases, then random phases.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lsc_pkg::*;

  localparam int NumPhases     = 8;
  localparam int ItemsPerPhase = 112;
  localparam int CycleLimit    = 100000;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  lsc_req_t        in_req    = '0;
  logic            out_ready = 1'b0;
  logic            cfg_we    = 1'b0;
  logic [CapW-1:0] cfg_wdata = CapReset;
  logic            in_ready;
  logic            out_valid;
  lsc_rsp_t        out_rsp;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int cycle_count   = 0;

  // Per-phase register settings, extremes included
  logic [CapW-1:0] phase_cap [NumPhases] = '{5'd16, 5'd1, 5'd31, 5'd2, 5'd5, 5'd0, 5'd12, 5'd16};
  logic [KeyW-1:0] key_pool [32];

  always #6 clk = ~clk;

  lru_sector_cache DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  lsc_cache_check cache_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_rsp_i    (out_rsp),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Stall the result side at the phase's rate.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("lru_sector_cache: mismatch");
      $finish;
    end
  end

  function automatic lsc_req_t cache_req(lsc_op_e op, logic [KeyW-1:0] addr,
                                         logic [HandleW-1:0] handle);
    lsc_req_t req;
    req.mode          = op;
    req.frame_address = addr;
    req.entry_ref     = handle;
    return req;
  endfunction

  // Present one request, idling first at the phase's rate, and hold it until taken.
  task automatic send_request(lsc_req_t req);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_req   = req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold off new requests until every result is back.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CapW-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  initial begin
    int          pool_n;
    int unsigned eff;
    int unsigned pick;
    lsc_req_t    req;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty cache, key extremes, replace, remove twice, flush with busy fields
    send_request(cache_req(OP_LOOKUP, 24'h000000, 16'h0000));
    send_request(cache_req(OP_REMOVE, 24'hFFFFFF, 16'hFFFF));
    send_request(cache_req(OP_INSERT, 24'h000000, 16'hFFFF));
    send_request(cache_req(OP_INSERT, 24'hFFFFFF, 16'h0000));
    send_request(cache_req(OP_LOOKUP, 24'h000000, 16'h0000));
    send_request(cache_req(OP_LOOKUP, 24'hFFFFFF, 16'hFFFF));
    send_request(cache_req(OP_INSERT, 24'h000000, 16'h1234));
    send_request(cache_req(OP_LOOKUP, 24'h000000, 16'h0000));
    send_request(cache_req(OP_REMOVE, 24'hFFFFFF, 16'h0000));
    send_request(cache_req(OP_REMOVE, 24'hFFFFFF, 16'h0000));
    send_request(cache_req(OP_FLUSH,  24'hFFFFFF, 16'hFFFF));
    send_request(cache_req(OP_LOOKUP, 24'h000000, 16'h0000));

    // Shrink capacity below occupancy: nothing drops, each new key evicts one
    send_request(cache_req(OP_INSERT, 24'hA5A5A5, 16'h0001));
    send_request(cache_req(OP_INSERT, 24'h5A5A5A, 16'h0002));
    send_request(cache_req(OP_INSERT, 24'h123456, 16'h0003));
    write_capacity(5'd1);
    send_request(cache_req(OP_INSERT, 24'h654321, 16'h0004));
    send_request(cache_req(OP_LOOKUP, 24'hA5A5A5, 16'h0000));

    // Capacity zero behaves as one
    send_request(cache_req(OP_FLUSH, 24'h000000, 16'h0000));
    write_capacity(5'd0);
    send_request(cache_req(OP_INSERT, 24'h0F0F0F, 16'hBEEF));
    send_request(cache_req(OP_INSERT, 24'hF0F0F0, 16'hCAFE));
    send_request(cache_req(OP_LOOKUP, 24'h0F0F0F, 16'h0000));

    // Random phases: a key pool a bit larger than capacity keeps hits and evictions common
    for (int ph = 0; ph < NumPhases; ph++) begin
      write_capacity(phase_cap[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 51; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 51; end
        default: begin send_idle_pct = 13; stall_pct = 13; end
      endcase
      eff    = (phase_cap[ph] == 0) ? 1 :
               (phase_cap[ph] > MaxEntries) ? MaxEntries : phase_cap[ph];
      pool_n = eff + $urandom_range(1, 5);
      for (int k = 0; k < pool_n; k++) key_pool[k] = KeyW'($urandom);

      for (int n = 0; n < ItemsPerPhase; n++) begin
        pick = $urandom_range(99);
        req  = cache_req(OP_LOOKUP, key_pool[$urandom_range(pool_n - 1)], HandleW'($urandom));
        if (pick < 35)      req.mode = OP_LOOKUP;
        else if (pick < 73) req.mode = OP_INSERT;
        else if (pick < 93) req.mode = OP_REMOVE;
        else if (pick < 95) req.mode = OP_FLUSH;
        else begin
          req.mode          = lsc_op_e'($urandom_range(3));
          req.frame_address = KeyW'($urandom);
        end
        send_request(req);
        // occasionally let the pipeline empty mid-phase
        if ($urandom_range(149) == 0) drain_results();
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("lru_sector_cache: match");
    end else begin
      $display("lru_sector_cache: mismatch");
    end
    $finish;
  end

endmodule
